FILE: rtl/sia_pkg.sv
// sia_pkg: operation codes, status codes and shared types for the scripted integer alu
// no dependencies
package sia_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned ModeW = 5;
    localparam int unsigned StatW = 2;
    localparam int unsigned DivCells = 32;

    typedef enum logic [ModeW-1:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
        OP_RSUB = 5'd5, OP_RDIV = 5'd6, OP_RMOD = 5'd7,
        OP_AND = 5'd8, OP_OR = 5'd9, OP_XOR = 5'd10,
        OP_SHL = 5'd11, OP_SHR = 5'd12, OP_ASR = 5'd13,
        OP_MAXU = 5'd14, OP_MINU = 5'd15, OP_MAXS = 5'd16, OP_MINS = 5'd17,
        OP_CMPS = 5'd18, OP_CMPU = 5'd19,
        OP_GEU = 5'd20, OP_LEU = 5'd21, OP_GES = 5'd22, OP_LES = 5'd23,
        OP_EQ = 5'd24, OP_NE = 5'd25
    } t_op;

    localparam logic [StatW-1:0] ST_OK = 2'd0;
    localparam logic [StatW-1:0] ST_RANGE = 2'd1;
    localparam logic [StatW-1:0] ST_DIVZERO = 2'd2;

    // data carried along the divider chain for one item
    typedef struct packed {
        logic             vld;
        logic             want_rem;
        logic             neg_q;
        logic             neg_r;
        logic             dz;
        logic             is_div;
        logic [DataW-1:0] quo;    // dividend bits shift out, quotient bits shift in
        logic [DataW:0]   rem;
        logic [DataW-1:0] dvs;    // divisor magnitude
        logic [DataW-1:0] res;    // non-divide result waiting alongside
        logic [StatW-1:0] st;
    } t_lane;

endpackage

FILE: rtl/sia_cell.sv
// sia_cell: one restoring-division step, registered, handing its lane to the next cell
// depends on sia_pkg
module sia_cell import sia_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_lane  i_lane,
    output t_lane  o_lane
);
    t_lane r_lane, n_lane;
    logic [DataW:0] sh, diff;

    always_comb begin
        n_lane = i_lane;
        sh = {i_lane.rem[DataW-1:0], i_lane.quo[DataW-1]};
        diff = sh - {1'b0, i_lane.dvs};
        if (i_lane.is_div) begin
            if (!diff[DataW]) begin
                n_lane.rem = diff;
                n_lane.quo = {i_lane.quo[DataW-2:0], 1'b1};
            end else begin
                n_lane.rem = sh;
                n_lane.quo = {i_lane.quo[DataW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.vld <= 1'b0;
        end else if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule

FILE: rtl/sia_front.sv
// sia_front: decodes the operation, computes every result other than divide and remainder, and loads the lane
// depends on sia_pkg
module sia_front import sia_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [ModeW-1:0] i_mode,
    input  logic [DataW-1:0] i_a,
    input  logic [DataW-1:0] i_b,
    output t_lane            o_lane
);
    t_lane r_lane, n_lane;
    logic [DataW-1:0] nd, dd, nd_mag, dd_mag, res, prod;
    logic [StatW-1:0] st;
    logic ltu, lts, eq, big, rev, is_dv, ok;

    assign ltu = i_a < i_b;
    assign lts = $signed(i_a) < $signed(i_b);
    assign eq = i_a == i_b;
    assign big = |i_b[DataW-1:5];
    assign prod = i_a * i_b;

    always_comb begin
        res = '0;
        ok = 1'b1;
        is_dv = 1'b0;
        rev = 1'b0;
        case (i_mode)
            OP_ADD:  res = i_a + i_b;
            OP_SUB:  res = i_a - i_b;
            OP_MUL:  res = prod;
            OP_DIV, OP_MOD: is_dv = 1'b1;
            OP_RSUB: res = i_b - i_a;
            OP_RDIV, OP_RMOD: begin
                is_dv = 1'b1;
                rev = 1'b1;
            end
            OP_AND:  res = i_a & i_b;
            OP_OR:   res = i_a | i_b;
            OP_XOR:  res = i_a ^ i_b;
            OP_SHL:  res = big ? '0 : i_a << i_b[4:0];
            OP_SHR:  res = big ? '0 : i_a >> i_b[4:0];
            OP_ASR:  res = big ? {DataW{i_a[DataW-1]}} : DataW'($signed(i_a) >>> i_b[4:0]);
            OP_MAXU: res = ltu ? i_b : i_a;
            OP_MINU: res = (!ltu && !eq) ? i_b : i_a;
            OP_MAXS: res = lts ? i_b : i_a;
            OP_MINS: res = (!lts && !eq) ? i_b : i_a;
            OP_CMPS: res = eq ? '0 : (lts ? '1 : DataW'(1));
            OP_CMPU: res = eq ? '0 : (ltu ? '1 : DataW'(1));
            OP_GEU:  begin res = i_a; ok = !ltu; end
            OP_LEU:  begin res = i_a; ok = ltu || eq; end
            OP_GES:  begin res = i_a; ok = !lts; end
            OP_LES:  begin res = i_a; ok = lts || eq; end
            OP_EQ:   begin res = i_a; ok = eq; end
            OP_NE:   begin res = i_a; ok = !eq; end
            default: res = '0;
        endcase
        st = ok ? ST_OK : ST_RANGE;
    end

    assign nd = rev ? i_b : i_a;
    assign dd = rev ? i_a : i_b;
    assign nd_mag = nd[DataW-1] ? -nd : nd;
    assign dd_mag = dd[DataW-1] ? -dd : dd;

    always_comb begin
        n_lane.vld = i_vld;
        n_lane.want_rem = (i_mode == OP_MOD) || (i_mode == OP_RMOD);
        n_lane.neg_q = nd[DataW-1] ^ dd[DataW-1];
        n_lane.neg_r = nd[DataW-1];
        n_lane.dz = is_dv && (dd == '0);
        n_lane.is_div = is_dv && (dd != '0);
        n_lane.quo = nd_mag;
        n_lane.rem = '0;
        n_lane.dvs = dd_mag;
        n_lane.res = res;
        n_lane.st = n_lane.dz ? ST_DIVZERO : st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.vld <= 1'b0;
        end else if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule

FILE: rtl/scripted_integer_alu_top.sv
// scripted_integer_alu_top: front decode stage, chain of division cells, output stage
// depends on sia_pkg, sia_front, sia_cell
//
//  channel | valid   | ready   | payload
//  in      | i_valid | o_ready | i_mode, i_operand_a, i_operand_b
//  out     | o_valid | i_ready | o_result, o_status
//
// one item enters per cycle while the output is not stalled; every operation passes the front stage,
// the chain of one-bit restoring division cells and then the output stage
// all items flow down the same chain, so order is kept
// a stall on the output freezes the whole chain; o_ready = !o_valid || i_ready
// synchronous active-low reset clears only the valid bits
module scripted_integer_alu_top import sia_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [ModeW-1:0]        i_mode,
    input  logic signed [DataW-1:0] i_operand_a,
    input  logic signed [DataW-1:0] i_operand_b,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [DataW-1:0] o_result,
    output logic [StatW-1:0]        o_status
);
    t_lane lane [DivCells+1];
    logic en;
    logic r_vld;
    logic [DataW-1:0] r_res, n_res;
    logic [StatW-1:0] r_st;
    logic [DataW-1:0] q_fix, r_fix;

    // the whole chain advances together unless the output holds a stalled transfer
    assign en = !r_vld || i_ready;
    assign o_ready = en;

    sia_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_valid),
        .i_mode(i_mode), .i_a(i_operand_a), .i_b(i_operand_b), .o_lane(lane[0])
    );

    // one quotient bit per cell; the chain length must equal the data width
    for (genvar g = 0; g < DivCells; g++) begin : g_cell
        sia_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_lane(lane[g]), .o_lane(lane[g+1])
        );
    end

    // sign correction; most negative over minus one wraps naturally
    t_lane last;
    assign last = lane[DivCells];
    assign q_fix = last.neg_q ? -last.quo : last.quo;
    assign r_fix = last.neg_r ? -last.rem[DataW-1:0] : last.rem[DataW-1:0];

    always_comb begin
        if (last.is_div) begin
            n_res = last.want_rem ? r_fix : q_fix;
        end else if (last.dz) begin
            n_res = '0;
        end else begin
            n_res = last.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= last.vld;
            r_res <= n_res;
            r_st <= last.st;
        end
    end

    assign o_valid = r_vld;
    assign o_result = r_res;
    assign o_status = r_st;
endmodule

FILE: rtl/sia_checker.sv
// sia_checker: port-level assertions for scripted_integer_alu_top, bound to the top level
// depends on sia_pkg
module sia_checker import sia_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic [DataW-1:0] o_result,
    input logic [StatW-1:0] o_status
);
    a_stat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_RANGE || o_status == ST_DIVZERO))
        else $error("bad status code");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DIVZERO) |-> (o_result == '0))
        else $error("divide error with nonzero result");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready) else $error("ready while output stalled");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result) && $stable(o_status)))
        else $error("stalled output changed");
endmodule

bind scripted_integer_alu_top sia_checker u_sia_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_result(o_result), .o_status(o_status)
);
